FILE: rtl/core/igy_pkg.sv
// shared types and constants for the vertical gradient block
`timescale 1ns / 1ps
package igy_pkg;

	// pixel and configuration widths
	localparam int PIX_W   = 16;
	localparam int WIDTH_W = 12;
	localparam int HEIGHT_W = 13;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 1;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;

	// reset values of the configuration registers
	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd480;

	// result queue depth and per-pixel result count width
	localparam int OQ_DEPTH = 2;
	localparam int CNT_W    = 2;

	// one line store entry: rows r-2 and r-1 at the same column
	typedef struct packed {
		logic signed [PIX_W-1:0] older;
		logic signed [PIX_W-1:0] newer;
	} lse_t;

endpackage

FILE: rtl/core/igy_line_store.sv
// dual-row line store: one synchronous memory, registered read, one write port
`timescale 1ns / 1ps
module igy_line_store #(
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output igy_pkg::lse_t            rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  igy_pkg::lse_t            wr_data
);
	import igy_pkg::*;

	lse_t mem [DEPTH];
	lse_t rd_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

FILE: rtl/core/igy_out_queue.sv
// two-entry result queue between the gradient stage and the output channel
`timescale 1ns / 1ps
module igy_out_queue #(
	parameter int DW = 42
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [igy_pkg::CNT_W-1:0]  push_n,
	input  logic [DW-1:0]              push_d0,
	input  logic [DW-1:0]              push_d1,
	output logic [igy_pkg::CNT_W-1:0]  space,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [DW-1:0]              out_data
);
	import igy_pkg::*;

	logic [DW-1:0]    ent_q [OQ_DEPTH];
	logic             head_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	logic             idx0;
	logic             idx1;

	// pop on an output transfer
	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && !out_stall;
	assign out_data  = ent_q[head_q];

	// free slots after this cycle's pop
	assign space = CNT_W'(3'(OQ_DEPTH) - 3'(cnt_q) + 3'(pop));

	// write slots follow the current tail
	assign idx0 = head_q ^ cnt_q[0];
	assign idx1 = ~idx0;

	always_ff @(posedge clk) begin
		if (push_n != '0) begin
			ent_q[idx0] <= push_d0;
		end
		if (push_n == CNT_W'(2)) begin
			ent_q[idx1] <= push_d1;
		end
	end

	// occupancy and head pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			head_q <= head_q ^ pop;
			cnt_q  <= cnt_q + push_n - CNT_W'(pop);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != CNT_W'(3))
		else $error("result queue occupancy out of range");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_n <= space)
		else $error("result queue pushed beyond free space");

	a_pop_only: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push_n == '0) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("result queue lost track of a pop");

endmodule

FILE: rtl/core/image_gradient_y_central.sv
// Vertical central-difference gradient of a raster-order signed 16-bit pixel stream.
// Input channel: pixel with in_valid / in_stall; a transfer happens when in_valid
// is high and in_stall low. Output channel: gradient, out_row, out_col,
// last_of_item and end_of_image with out_valid / out_stall, same rule.
// Configuration: wr_en, wr_index (0 = image_width, 1 = image_height), wr_data;
// write only while the block is idle.
// Results lag the input by one row: a pixel of row r gives the derivative of
// row r-1 at its column; row 0 gives no result; a last-row pixel gives two
// (row r-1, then its own row), after which the counters return to row 0.
// Throughput is one pixel per clock while in_stall is low: the line store is
// read at the input transfer and written back when the gradient stage fires,
// with forwarding when the next pixel reads the entry being written (images one
// pixel wide). Last-row pixels give two results each, so that row is held back
// by the single output port. When the receiver stalls, a two-entry result
// queue absorbs results and then in_stall rises.
// Reset clears counters, queue and the stage valid; the line store itself
// needs no clearing pass (entries are written before read).
`timescale 1ns / 1ps
module image_gradient_y_central #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [igy_pkg::IDX_W-1:0]           wr_index,
	input  logic [igy_pkg::CFG_W-1:0]           wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [igy_pkg::PIX_W-1:0]    pixel,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [igy_pkg::PIX_W-1:0]    gradient,
	output logic [$clog2(MAX_HEIGHT)-1:0]       out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]        out_col,
	output logic                                last_of_item,
	output logic                                end_of_image
);
	import igy_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int DW = PIX_W + RW + CW + 2;

	// configuration registers
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH:  width_q  <= wr_data[WIDTH_W-1:0];
				REG_HEIGHT: height_q <= wr_data;
				default:    ;
			endcase
		end
	end

	// clamped last column and last row
	logic [CW-1:0] wm1;
	logic [RW-1:0] hm1;

	always_comb begin
		if (width_q == '0) begin
			wm1 = '0;
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			wm1 = CW'(MAX_WIDTH - 1);
		end else begin
			wm1 = CW'(width_q - WIDTH_W'(1));
		end
	end

	always_comb begin
		if (32'(height_q) < 32'd2) begin
			hm1 = RW'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			hm1 = RW'(MAX_HEIGHT - 1);
		end else begin
			hm1 = RW'(height_q - HEIGHT_W'(1));
		end
	end

	// position counters
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          row_end;
	logic          last_row;
	logic          in_xfer;

	assign row_end  = (col_q >= wm1);
	assign last_row = (row_q >= hm1);
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// gradient stage registers
	logic                    valid_s1;
	logic signed [PIX_W-1:0] pix_s1;
	logic [CW-1:0]           col_s1;
	logic [RW-1:0]           row_s1;
	logic                    last_row_s1;
	logic                    row_end_s1;
	logic                    fwd_s1;
	lse_t                    fwd_data_s1;

	logic             s1_fire;
	logic [CNT_W-1:0] n_s1;
	logic [CNT_W-1:0] space;
	lse_t             rd_data;
	lse_t             line;
	lse_t             wb_data;
	logic             fwd_hit;

	// write-back entry: previous row shifts to older, this pixel becomes newer
	assign wb_data.older = line.newer;
	assign wb_data.newer = pix_s1;
	assign fwd_hit       = s1_fire && (col_s1 == col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1      <= pixel;
			col_s1      <= col_q;
			row_s1      <= row_q;
			last_row_s1 <= last_row;
			row_end_s1  <= row_end;
			fwd_s1      <= fwd_hit;
			fwd_data_s1 <= wb_data;
		end
	end

	igy_line_store #(
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk     (clk),
		.rd_en   (in_xfer),
		.rd_addr (col_q),
		.rd_data (rd_data),
		.wr_en   (s1_fire),
		.wr_addr (col_s1),
		.wr_data (wb_data)
	);

	// entry written by the previous pixel in the read cycle comes from the bypass
	assign line = fwd_s1 ? fwd_data_s1 : rd_data;

	// differences against the rows above
	logic signed [PIX_W:0]   d_new;
	logic signed [PIX_W:0]   d_old;
	logic signed [PIX_W-1:0] g_first;
	logic signed [PIX_W-1:0] g_own;

	assign d_new   = {pix_s1[PIX_W-1], pix_s1} - {line.newer[PIX_W-1], line.newer};
	assign d_old   = {pix_s1[PIX_W-1], pix_s1} - {line.older[PIX_W-1], line.older};
	assign g_own   = d_new[PIX_W-1:0];
	assign g_first = (row_s1 == RW'(1)) ? g_own : d_old[PIX_W:1];

	// results per pixel: none on row zero, two on the last row
	always_comb begin
		if (!valid_s1 || row_s1 == '0) begin
			n_s1 = '0;
		end else if (last_row_s1) begin
			n_s1 = CNT_W'(2);
		end else begin
			n_s1 = CNT_W'(1);
		end
	end

	assign s1_fire  = valid_s1 && (n_s1 <= space);
	assign in_stall = valid_s1 && !s1_fire;

	logic [DW-1:0] res0;
	logic [DW-1:0] res1;
	logic [DW-1:0] out_data;

	assign res0 = {g_first, row_s1 - RW'(1), col_s1, !last_row_s1, 1'b0};
	assign res1 = {g_own, row_s1, col_s1, 1'b1, row_end_s1};

	igy_out_queue #(
		.DW (DW)
	) u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (s1_fire ? n_s1 : CNT_W'(0)),
		.push_d0   (res0),
		.push_d1   (res1),
		.space     (space),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	assign {gradient, out_row, out_col, last_of_item, end_of_image} = out_data;

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted pixel missing from gradient stage");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_fire) |=> (valid_s1 && $stable(pix_s1) && $stable(col_s1)))
		else $error("stalled gradient stage changed");

	a_bypass_set: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s1_fire && col_s1 == col_q) |=> fwd_s1)
		else $error("same-entry read missed the bypass");

	a_no_push_row0: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && row_s1 == '0) |-> n_s1 == '0)
		else $error("row zero produced a result");

endmodule
